/* sv/mas_pkg.sv */
package mas_pkg;

  // stick command width
  localparam int unsigned STICK_BITS = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_OFF    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHECK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_CHECK = 2'd2;

  localparam logic [CFG_DATA_W-1:0] HOLD_OFF_RST    = 8'd80;
  localparam logic [CFG_DATA_W-1:0] FIRST_CHECK_RST = 8'd21;
  localparam logic [CFG_DATA_W-1:0] FINAL_CHECK_RST = 8'd41;

  // failsafe scale 99/100: floor(t*99/100) == (t * ceil(2^30/100) * 99) >> 30 for 16-bit t
  localparam int unsigned SCALE_SHIFT = 30;
  localparam int unsigned SCALE_W     = 30;
  localparam logic [SCALE_W-1:0] SCALE_MUL = 30'd1063004481;
  localparam int unsigned PROD_W = STICK_BITS + SCALE_W;

  // item opcodes
  typedef enum logic [1:0] {
    OP_FRAME   = 2'd0,
    OP_OVR_ON  = 2'd1,
    OP_OVR_OFF = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  // arming mode
  typedef enum logic [3:0] {
    M_AWAIT      = 4'd0,
    M_DISABLED   = 4'd1,
    M_ENABLING   = 4'd2,
    M_LOCKED     = 4'd3,
    M_ENABLED    = 4'd4,
    M_FAIL_STAB  = 4'd5,
    M_FAIL_ANGLE = 4'd6,
    M_FAIL_RX    = 4'd7,
    M_OVERRIDE   = 4'd8
  } mode_t;

  // status bit positions
  localparam int unsigned ST_IDLE     = 0;
  localparam int unsigned ST_ARMING   = 1;
  localparam int unsigned ST_NO_SIG   = 2;
  localparam int unsigned ST_ARMED    = 3;
  localparam int unsigned ST_OVERRIDE = 4;

  // failure codes
  localparam logic [1:0] FAIL_NONE  = 2'd0;
  localparam logic [1:0] FAIL_STAB  = 2'd1;
  localparam logic [1:0] FAIL_ANGLE = 2'd2;
  localparam logic [1:0] FAIL_ARM   = 2'd3;

  typedef struct packed {
    logic [1:0]                   op;
    logic                         rx_timeout;
    logic                         arm_switch_low;
    logic [STICK_BITS-1:0]        throttle_in;
    logic signed [STICK_BITS-1:0] pitch_in;
    logic signed [STICK_BITS-1:0] roll_in;
    logic signed [STICK_BITS-1:0] yaw_in;
    logic                         is_upright;
    logic                         is_stable;
  } in_t;

  typedef struct packed {
    logic [STICK_BITS-1:0]        throttle_out;
    logic signed [STICK_BITS-1:0] pitch_out;
    logic signed [STICK_BITS-1:0] roll_out;
    logic signed [STICK_BITS-1:0] yaw_out;
    logic [3:0]                   mode_code;
    logic                         motors_on;
    logic [4:0]                   status_bits;
    logic [1:0]                   fail_code;
    logic                         calibrate_request;
    logic                         log_open_request;
    logic                         log_close_request;
  } out_t;

endpackage

/* sv/motor_arming_sequencer.sv */
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall   mas_pkg::in_t  (one frame or override op)
// out_      output     out_valid/out_stall mas_pkg::out_t (one result per item)
// cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// One item per cycle sustained without out_stall; each result passes the input register,
// then one mode update into the result register.
// The mode, counters and motor flag change in the cycle the item leaves the input register.
// Reset (rst_n low, synchronous) empties both registers, sets mode to await-disarm,
// clears counters and loads the default configuration.
// A stalled result holds; the input register still fills behind it, then in_stall rises.
module motor_arming_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mas_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mas_pkg::out_t                       out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mas_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mas_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // configuration registers
  logic [mas_pkg::CFG_DATA_W-1:0] hold_off_frames_r, first_check_r, final_check_r;

  // pipeline registers
  logic          s1_valid_r;
  mas_pkg::in_t  s1_r;
  logic          out_valid_r;
  mas_pkg::out_t out_r;

  // arming state
  mas_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]     cnt_r, cnt_nxt;
  logic           mot_r, mot_nxt;
  logic [7:0]     hold_r, hold_nxt;
  mas_pkg::out_t  res_nxt;

  logic s1_adv, in_acc;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_off_frames_r <= mas_pkg::HOLD_OFF_RST;
      first_check_r     <= mas_pkg::FIRST_CHECK_RST;
      final_check_r     <= mas_pkg::FINAL_CHECK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mas_pkg::CFG_HOLD_OFF:    hold_off_frames_r <= cfg_data;
        mas_pkg::CFG_FIRST_CHECK: first_check_r     <= cfg_data;
        mas_pkg::CFG_FINAL_CHECK: final_check_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // failsafe throttle scaling
  logic [mas_pkg::PROD_W-1:0]     scale_prod;
  logic [mas_pkg::STICK_BITS-1:0] thr_scaled;
  assign scale_prod = {{mas_pkg::SCALE_W{1'b0}}, s1_r.throttle_in}
                    * {{mas_pkg::STICK_BITS{1'b0}}, mas_pkg::SCALE_MUL};
  assign thr_scaled = scale_prod[mas_pkg::SCALE_SHIFT +: mas_pkg::STICK_BITS];

  // mode update and stick gating for the item in the input register
  always_comb begin
    mas_pkg::mode_t m;
    logic [mas_pkg::STICK_BITS-1:0] thr, pit, rol, yaw;
    logic [7:0] cnt, hold;
    logic mot, cal, lopen, lclose, gate;

    m = mode_r;
    cnt = cnt_r;
    hold = hold_r;
    mot = mot_r;
    cal = 1'b0;
    lopen = 1'b0;
    lclose = 1'b0;
    gate = 1'b0;
    thr = s1_r.throttle_in;
    pit = s1_r.pitch_in;
    rol = s1_r.roll_in;
    yaw = s1_r.yaw_in;

    if (mas_pkg::op_t'(s1_r.op) != mas_pkg::OP_FRAME) begin
      // override commands; any non-frame op zeroes the sticks
      if (mas_pkg::op_t'(s1_r.op) == mas_pkg::OP_OVR_ON) begin
        m = mas_pkg::M_OVERRIDE;
      end else if (mas_pkg::op_t'(s1_r.op) == mas_pkg::OP_OVR_OFF
                   && m == mas_pkg::M_OVERRIDE) begin
        m = mas_pkg::M_AWAIT;
      end
      thr = '0;
      pit = '0;
      rol = '0;
      yaw = '0;
    end else begin
      // receiver link
      if (s1_r.rx_timeout) begin
        if (m != mas_pkg::M_OVERRIDE) m = mas_pkg::M_FAIL_RX;
      end else if (m == mas_pkg::M_FAIL_RX) begin
        m = mas_pkg::M_AWAIT;
      end

      // arm switch
      unique case (m)
        mas_pkg::M_OVERRIDE: ;
        mas_pkg::M_DISABLED: begin
          if (s1_r.arm_switch_low) begin
            m = mas_pkg::M_ENABLING;
            cnt = '0;
          end
        end
        mas_pkg::M_LOCKED: begin
          if (!s1_r.arm_switch_low) m = mas_pkg::M_DISABLED;
          else if (s1_r.throttle_in == '0) m = mas_pkg::M_ENABLED;
        end
        mas_pkg::M_FAIL_RX: thr = thr_scaled;
        default: begin
          if (!s1_r.arm_switch_low) m = mas_pkg::M_DISABLED;
        end
      endcase

      // enabling count and checkpoints
      if (m == mas_pkg::M_ENABLING) begin
        if (!mot) begin
          if (cnt == '0) begin
            cnt = 8'd1;
          end else begin
            cnt = cnt + 8'd1;
            if (!s1_r.is_upright) begin
              m = mas_pkg::M_FAIL_ANGLE;
            end else if (cnt == first_check_r) begin
              if (!s1_r.is_stable) m = mas_pkg::M_FAIL_STAB;
              else cal = 1'b1;
            end else if (cnt == final_check_r) begin
              if (!s1_r.is_stable) begin
                m = mas_pkg::M_FAIL_STAB;
              end else begin
                lopen = 1'b1;
                mot = 1'b1;
                m = mas_pkg::M_LOCKED;
              end
            end
          end
          hold = hold_off_frames_r;
        end
      end else if (m == mas_pkg::M_DISABLED) begin
        mot = 1'b0;
        lclose = 1'b1;
      end

      // hold-off and throttle gating
      if (!s1_r.rx_timeout) begin
        if (hold != '0) begin
          hold = hold - 8'd1;
          gate = 1'b1;
        end
        if (gate || thr == '0 || m == mas_pkg::M_LOCKED) begin
          thr = '0;
          pit = '0;
          rol = '0;
          yaw = '0;
        end
      end
    end

    mode_nxt = m;
    cnt_nxt = cnt;
    hold_nxt = hold;
    mot_nxt = mot;

    res_nxt.throttle_out = thr;
    res_nxt.pitch_out = pit;
    res_nxt.roll_out = rol;
    res_nxt.yaw_out = yaw;
    res_nxt.mode_code = m;
    res_nxt.motors_on = mot;
    res_nxt.status_bits = '0;
    res_nxt.fail_code = mas_pkg::FAIL_NONE;
    res_nxt.calibrate_request = cal;
    res_nxt.log_open_request = lopen;
    res_nxt.log_close_request = lclose;

    // status and failure decode
    unique case (m)
      mas_pkg::M_DISABLED:   res_nxt.status_bits[mas_pkg::ST_IDLE] = 1'b1;
      mas_pkg::M_ENABLING:   res_nxt.status_bits[mas_pkg::ST_ARMING] = 1'b1;
      mas_pkg::M_FAIL_RX:    res_nxt.status_bits[mas_pkg::ST_NO_SIG] = 1'b1;
      mas_pkg::M_ENABLED:    res_nxt.status_bits[mas_pkg::ST_ARMED] = 1'b1;
      mas_pkg::M_OVERRIDE:   res_nxt.status_bits[mas_pkg::ST_OVERRIDE] = 1'b1;
      mas_pkg::M_FAIL_STAB: begin
        res_nxt.status_bits[mas_pkg::ST_ARMING] = 1'b1;
        res_nxt.fail_code = mas_pkg::FAIL_STAB;
      end
      mas_pkg::M_FAIL_ANGLE: begin
        res_nxt.status_bits[mas_pkg::ST_ARMING] = 1'b1;
        res_nxt.fail_code = mas_pkg::FAIL_ANGLE;
      end
      default: begin
        // await disarm, throttle lock
        res_nxt.status_bits[mas_pkg::ST_ARMING] = 1'b1;
        res_nxt.fail_code = mas_pkg::FAIL_ARM;
      end
    endcase
  end

  // arming state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mas_pkg::M_AWAIT;
      cnt_r  <= '0;
      mot_r  <= 1'b0;
      hold_r <= '0;
    end else if (s1_adv) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      mot_r  <= mot_nxt;
      hold_r <= hold_nxt;
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;
      if (s1_adv) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) s1_r <= in_data;
    if (s1_adv) out_r <= res_nxt;
  end

endmodule

/* sv/mas_checker.sv */
module mas_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input mas_pkg::out_t out_data
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // exactly one status flag per result
  a_status_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(out_data.status_bits))
    else $error("status flags not one-hot");

  // motors enable into throttle lock
  a_log_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.log_open_request |->
      out_data.motors_on && out_data.mode_code == 4'(mas_pkg::M_LOCKED))
    else $error("log open without motor enable");

  // calibration only while the count runs
  a_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.calibrate_request |->
      out_data.mode_code == 4'(mas_pkg::M_ENABLING) && !out_data.motors_on)
    else $error("calibration outside enabling");

  // log close comes with motors off in disabled mode
  a_log_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.log_close_request |->
      !out_data.motors_on && out_data.mode_code == 4'(mas_pkg::M_DISABLED))
    else $error("log close outside disabled mode");

endmodule

bind motor_arming_sequencer mas_checker u_mas_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
